### hw/rtl/ucdc_pkg.sv
`timescale 1ns / 1ps

package ucdc_pkg;

    // Descriptor codes
    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] CLASS_AUDIO    = 8'd1;
    localparam logic [7:0] CLASS_HID      = 8'd3;
    localparam logic [7:0] SUBCLASS_BOOT  = 8'd1;
    localparam logic [7:0] SUBCLASS_MIDI  = 8'd3;
    localparam logic [7:0] PROTO_KEYBOARD = 8'd1;
    localparam logic [7:0] PROTO_MOUSE    = 8'd2;
    localparam logic [7:0] IN_BIT         = 8'h80;
    localparam logic [7:0] EP_MASK        = 8'h7f;

    // Byte offsets inside a descriptor
    localparam logic [7:0] POS_LENGTH   = 8'd0;
    localparam logic [7:0] POS_TYPE     = 8'd1;
    localparam logic [7:0] POS_ADDRESS  = 8'd2;
    localparam logic [7:0] POS_CLASS    = 8'd5;
    localparam logic [7:0] POS_SUBCLASS = 8'd6;
    localparam logic [7:0] POS_PROTOCOL = 8'd7;

    typedef enum logic [1:0] {
        TARGET_NONE     = 2'd0,
        TARGET_KEYBOARD = 2'd1,
        TARGET_MOUSE    = 2'd2,
        TARGET_MIDI     = 2'd3
    } target_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [6:0] keyboard_endpoint;
        logic [6:0] mouse_endpoint;
        logic [6:0] midi_endpoint;
        logic       supported;
        logic       malformed;
    } result_word_t;

endpackage

### hw/rtl/usb_config_descriptor_classifier_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+----------------------------
// byte     | in        | byte_valid / byte_stall    | byte_word   (ucdc_pkg::byte_word_t)
// result   | out       | result_valid / result_stall| result_word (ucdc_pkg::result_word_t)
//
// One byte word is taken every cycle while byte_stall is low; parser state updates
// at the edge that takes it, and a last byte's result word goes to the output in
// the next cycle if the output slot is empty or being read, else to the skid slot.
// Throughput is set by the output register plus a one-word skid register: byte_stall
// rises only when both hold a word, and drops the cycle after the sink takes one.
// rst_n (asynchronous, active low) clears the parser state and both output slots.
// A stalled result word holds until result_stall drops.
module usb_config_descriptor_classifier_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  ucdc_pkg::byte_word_t   byte_word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output ucdc_pkg::result_word_t result_word
);

    // Parser state
    logic [7:0]        pos_reg,    pos_next;
    logic [7:0]        len_reg,    len_next;
    logic [7:0]        type_reg,   type_next;
    logic [7:0]        class_reg,  class_next;
    logic [7:0]        sub_reg,    sub_next;
    ucdc_pkg::target_t sel_reg,    sel_next;
    logic [6:0]        kbd_reg,    kbd_next;
    logic [6:0]        mouse_reg,  mouse_next;
    logic [6:0]        midi_reg,   midi_next;
    logic              mal_reg,    mal_next;

    // Output slot and skid slot
    logic                   out_valid_reg,  out_valid_next;
    ucdc_pkg::result_word_t out_word_reg,   out_word_next;
    logic                   skid_valid_reg, skid_valid_next;
    ucdc_pkg::result_word_t skid_word_reg,  skid_word_next;

    logic                   accept;
    logic                   push;
    logic                   pop;
    logic [7:0]             len_eff;
    ucdc_pkg::target_t      chosen;
    ucdc_pkg::result_word_t result_now;

    assign accept = byte_valid && !byte_stall;
    assign push   = accept && byte_word.last_byte;
    assign pop    = out_valid_reg && !result_stall;

    // Target picked by an interface descriptor's protocol byte
    always_comb
    begin
        chosen = ucdc_pkg::TARGET_NONE;
        if (class_reg == ucdc_pkg::CLASS_HID && sub_reg == ucdc_pkg::SUBCLASS_BOOT)
        begin
            if (byte_word.data_byte == ucdc_pkg::PROTO_KEYBOARD)
                chosen = ucdc_pkg::TARGET_KEYBOARD;
            else if (byte_word.data_byte == ucdc_pkg::PROTO_MOUSE)
                chosen = ucdc_pkg::TARGET_MOUSE;
        end
        else if (class_reg == ucdc_pkg::CLASS_AUDIO && sub_reg == ucdc_pkg::SUBCLASS_MIDI)
        begin
            chosen = ucdc_pkg::TARGET_MIDI;
        end
    end

    // Parser next state
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        class_next = class_reg;
        sub_next   = sub_reg;
        sel_next   = sel_reg;
        kbd_next   = kbd_reg;
        mouse_next = mouse_reg;
        midi_next  = midi_reg;
        mal_next   = mal_reg;
        len_eff    = len_reg;

        if (accept)
        begin
            // A first byte starts a new set
            if (byte_word.first_byte)
            begin
                pos_next   = ucdc_pkg::POS_LENGTH;
                sel_next   = ucdc_pkg::TARGET_NONE;
                kbd_next   = '0;
                mouse_next = '0;
                midi_next  = '0;
                mal_next   = 1'b0;
            end

            // After a zero length byte, drop everything until the next first byte
            if (!mal_next)
            begin
                len_eff = (pos_next == ucdc_pkg::POS_LENGTH) ? byte_word.data_byte : len_reg;
                case (pos_next)
                    ucdc_pkg::POS_LENGTH:
                    begin
                        len_next = byte_word.data_byte;
                        if (byte_word.data_byte == 8'd0)
                            mal_next = 1'b1;
                    end
                    ucdc_pkg::POS_TYPE:
                    begin
                        type_next = byte_word.data_byte;
                        if (byte_word.data_byte == ucdc_pkg::TYPE_INTERFACE)
                            sel_next = ucdc_pkg::TARGET_NONE;
                    end
                    ucdc_pkg::POS_ADDRESS:
                    begin
                        if (type_reg == ucdc_pkg::TYPE_ENDPOINT
                            && (byte_word.data_byte & ucdc_pkg::IN_BIT) != 8'd0
                            && sel_next != ucdc_pkg::TARGET_NONE)
                        begin
                            case (sel_next)
                                ucdc_pkg::TARGET_KEYBOARD: kbd_next   = byte_word.data_byte[6:0];
                                ucdc_pkg::TARGET_MOUSE:    mouse_next = byte_word.data_byte[6:0];
                                ucdc_pkg::TARGET_MIDI:     midi_next  = byte_word.data_byte[6:0];
                                default:                   ;
                            endcase
                            sel_next = ucdc_pkg::TARGET_NONE;
                        end
                    end
                    ucdc_pkg::POS_CLASS:    class_next = byte_word.data_byte;
                    ucdc_pkg::POS_SUBCLASS: sub_next   = byte_word.data_byte;
                    ucdc_pkg::POS_PROTOCOL:
                    begin
                        if (type_reg == ucdc_pkg::TYPE_INTERFACE)
                            sel_next = chosen;
                    end
                    default: ;
                endcase

                // Advance the offset, wrap at the end of the descriptor
                if (!mal_next)
                begin
                    if ({1'b0, pos_next} + 9'd1 >= {1'b0, len_eff})
                        pos_next = ucdc_pkg::POS_LENGTH;
                    else
                        pos_next = pos_next + 8'd1;
                end
            end
        end
    end

    always_comb
    begin
        result_now.keyboard_endpoint = kbd_next;
        result_now.mouse_endpoint    = mouse_next;
        result_now.midi_endpoint     = midi_next;
        result_now.supported         = (kbd_next | mouse_next | midi_next) != 7'd0;
        result_now.malformed         = mal_next;
    end

    // Output slot fills from the skid first; the skid takes a word only while
    // the output slot is held by a stall
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_word_next  = result_now;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = result_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            len_reg        <= '0;
            type_reg       <= '0;
            class_reg      <= '0;
            sub_reg        <= '0;
            sel_reg        <= ucdc_pkg::TARGET_NONE;
            kbd_reg        <= '0;
            mouse_reg      <= '0;
            midi_reg       <= '0;
            mal_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            type_reg       <= type_next;
            class_reg      <= class_next;
            sub_reg        <= sub_next;
            sel_reg        <= sel_next;
            kbd_reg        <= kbd_next;
            mouse_reg      <= mouse_next;
            midi_reg       <= midi_next;
            mal_reg        <= mal_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload slots need no reset
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign byte_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

### hw/rtl/ucdc_checker.sv
`timescale 1ns / 1ps

module ucdc_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   byte_valid,
    input logic                   byte_stall,
    input ucdc_pkg::byte_word_t   byte_word,
    input logic                   result_valid,
    input logic                   result_stall,
    input ucdc_pkg::result_word_t result_word
);

    a_supported_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.supported ==
            ((result_word.keyboard_endpoint | result_word.mouse_endpoint
              | result_word.midi_endpoint) != 7'd0))
        else $error("supported flag disagrees with endpoints");

    a_stalled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("stalled result word changed");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid)
        else $error("byte stall without a pending result");

    a_zero_length_set: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && !result_valid && byte_word.first_byte
        && byte_word.last_byte && byte_word.data_byte == 8'd0
        |=> result_valid && result_word.malformed && !result_word.supported)
        else $error("single zero byte did not report malformed");

    a_single_byte_set: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && !result_valid && byte_word.first_byte
        && byte_word.last_byte && byte_word.data_byte != 8'd0
        |=> result_valid && !result_word.malformed && !result_word.supported)
        else $error("single length byte reported endpoints or malformed");

endmodule

bind usb_config_descriptor_classifier_top ucdc_checker u_ucdc_checker (.*);
